[design/akvs_pkg.sv]
// ----------------------------------------------------------------------------
// akvs_pkg
// Shared sizes, status codes, state type and byte mask helper for the
// attribute key/value store.
// ----------------------------------------------------------------------------
`default_nettype none

package akvs_pkg;

   localparam int NUM_ENTRIES = 16;
   localparam int MAX_LEN     = 8;
   localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int KEY_W       = 8;
   localparam int LEN_W       = 4;
   localparam int REQ_LEN_W   = 8;
   localparam int VAL_W       = 64;
   localparam int VAL_BYTES   = VAL_W / 8;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FAIL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RESP
   } state_type;

   // ones in every byte lane below len
   function automatic logic [VAL_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
      logic [VAL_W-1:0] m;
      m = '0;
      for (int b = 0; b < VAL_BYTES; b++) begin
         if (LEN_W'(b) < len) begin
            m[b*8 +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

[design/akvs_if.sv]
// ----------------------------------------------------------------------------
// akvs channel interfaces
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface akvs_req_if import akvs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic [KEY_W-1:0]     attr_key;
   logic [REQ_LEN_W-1:0] value_len;
   logic [VAL_W-1:0]     value_in;

   modport source (output valid, output operation, output attr_key,
                   output value_len, output value_in, input ready);
   modport sink   (input valid, input operation, input attr_key,
                   input value_len, input value_in, output ready);
endinterface

interface akvs_rsp_if import akvs_pkg::*; ();
   logic             valid;
   logic             ready;
   status_type       status;
   logic [LEN_W-1:0] out_len;
   logic [VAL_W-1:0] value_out;

   modport source (output valid, output status, output out_len,
                   output value_out, input ready);
   modport sink   (input valid, input status, input out_len,
                   input value_out, output ready);
endinterface

`default_nettype wire

[design/attribute_key_value_store.sv]
// ----------------------------------------------------------------------------
// attribute_key_value_store
// Small table of attributes (key, length, up to eight value bytes).
//
// req_chan carries one get or set word; rsp_chan returns one response word
// (status, length, value) for each request. A get returns the lowest live
// entry with a matching key; a set writes the lowest entry that matches or
// is empty. A set longer than the maximum length fails right away.
// The table is scanned one entry per cycle through a single key compare,
// so a too long set is answered in the cycle after it is accepted, and any
// other request goes from S_IDLE through S_SCAN (up to the hit) to S_RESP.
// The request side is ready only while idle, so one request goes through
// at a time; the next request is taken only after the receiver has taken
// the response word.
// The response word is held in registers until rsp_chan.ready; no new
// request is taken meanwhile. Synchronous reset empties every entry at
// once (all lengths zero) and returns the block to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module attribute_key_value_store import akvs_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   akvs_req_if.sink   req_chan,
   akvs_rsp_if.source rsp_chan
);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic             op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [LEN_W-1:0] len_ff;
   logic [VAL_W-1:0] val_ff;

   status_type       status_ff;
   logic [LEN_W-1:0] out_len_ff;
   logic [VAL_W-1:0] value_out_ff;

   logic [KEY_W-1:0] key_mem_ff   [NUM_ENTRIES];
   logic [LEN_W-1:0] len_mem_ff   [NUM_ENTRIES];
   logic [VAL_W-1:0] bytes_mem_ff [NUM_ENTRIES];

   logic [KEY_W-1:0] rd_key;
   logic [LEN_W-1:0] rd_len;
   logic [VAL_W-1:0] rd_bytes;
   logic             key_eq, hit, last, too_long, accept;
   logic             wr_en, res_load;
   status_type       res_status;
   logic [LEN_W-1:0] res_len;
   logic [VAL_W-1:0] res_val;

   // entry under the scan pointer
   assign rd_key   = key_mem_ff[idx_ff];
   assign rd_len   = len_mem_ff[idx_ff];
   assign rd_bytes = bytes_mem_ff[idx_ff];
   assign key_eq   = (rd_key == key_ff);
   assign hit      = op_ff ? (key_eq || rd_len == '0) : (key_eq && rd_len != '0);
   assign last     = (idx_ff == IDX_W'(NUM_ENTRIES - 1));
   assign too_long = (req_chan.value_len > REQ_LEN_W'(MAX_LEN));
   assign accept   = req_chan.valid && (state_ff == S_IDLE);

   assign req_chan.ready     = (state_ff == S_IDLE);
   assign rsp_chan.valid     = (state_ff == S_RESP);
   assign rsp_chan.status    = status_ff;
   assign rsp_chan.out_len   = out_len_ff;
   assign rsp_chan.value_out = value_out_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_chan.operation && too_long) ? S_RESP : S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit || last) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      idx_in     = idx_ff;
      wr_en      = 1'b0;
      res_load   = 1'b0;
      res_status = status_ff;
      res_len    = '0;
      res_val    = '0;
      case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (accept && req_chan.operation && too_long) begin
               res_load   = 1'b1;
               res_status = ST_FAIL;
            end
         end
         S_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (hit) begin
               res_load   = 1'b1;
               res_status = ST_OK;
               if (op_ff) begin
                  wr_en = 1'b1;
               end else begin
                  res_len = rd_len;
                  res_val = rd_bytes & byte_mask(rd_len);
               end
            end else if (last) begin
               res_load   = 1'b1;
               res_status = op_ff ? ST_FAIL : ST_NOT_FOUND;
            end
         end
         S_RESP: begin
            idx_in = '0;
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // request word capture; bytes past the length are dropped here
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_chan.operation;
         key_ff <= req_chan.attr_key;
         len_ff <= req_chan.value_len[LEN_W-1:0];
         val_ff <= req_chan.value_in & byte_mask(req_chan.value_len[LEN_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         status_ff    <= res_status;
         out_len_ff   <= res_len;
         value_out_ff <= res_val;
      end
   end

   // zero length marks an empty entry
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            len_mem_ff[i] <= '0;
         end
      end else if (wr_en) begin
         len_mem_ff[idx_ff] <= len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[idx_ff]   <= key_ff;
         bytes_mem_ff[idx_ff] <= val_ff;
      end
   end

`ifndef ASSERT_OFF
   a_ready_not_while_rsp: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !rsp_chan.valid)
      else $error("request taken while a response word is pending");

   a_too_long_fails: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.operation &&
       req_chan.value_len > REQ_LEN_W'(MAX_LEN))
      |=> (rsp_chan.valid && rsp_chan.status == ST_FAIL))
      else $error("too long set did not fail at once");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != ST_OK)
      |-> (rsp_chan.out_len == '0 && rsp_chan.value_out == '0))
      else $error("failed response carries data");
`endif

endmodule

`default_nettype wire
